>>> design/pgsd_pkg.sv
// ----------------------------------------------------------------------------
// pgsd_pkg: shared types and constants
// Register indexes, status codes, sequencer states and the snap unit status
// bundle for the polyline grid snap and dedup block.
// ----------------------------------------------------------------------------
package pgsd_pkg;

    localparam int STEP_W     = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int GRID_STEP_RESET = 256;

    localparam int MIN_LINE_PTS = 2;
    localparam int MIN_RING_PTS = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_STEP = 1'b0,
        REG_RING_MODE = 1'b1
    } pgsd_cfg_idx_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TOO_FEW  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } pgsd_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Y,
        ST_CHECK,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_COMMIT,
        ST_EMIT_VTX,
        ST_FINISH,
        ST_CLOSE_RD,
        ST_EMIT_CLOSE,
        ST_EMIT_END
    } pgsd_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pgsd_snap_stat_t;

endpackage

>>> design/pgsd_snap_unit.sv
// ----------------------------------------------------------------------------
// pgsd_snap_unit: iterative grid snap of one coordinate
// Restoring division of the magnitude by the grid step, one bit per cycle.
// The snapped value is the coordinate moved toward zero by the remainder.
// ----------------------------------------------------------------------------
module pgsd_snap_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [COORD_WIDTH-1:0]   operand,
    input  logic [pgsd_pkg::STEP_W-1:0]     step,
    output pgsd_pkg::pgsd_snap_stat_t       stat,
    output logic signed [COORD_WIDTH-1:0]   result
);
    import pgsd_pkg::*;

    localparam int RW    = (COORD_WIDTH > STEP_W) ? COORD_WIDTH : STEP_W;
    localparam int CNT_W = $clog2(COORD_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COORD_WIDTH - 1);

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [COORD_WIDTH-1:0] mag_reg;
    logic [RW-1:0]          rem_reg;
    logic [COORD_WIDTH-1:0] orig_reg;

    logic [RW:0]            trial;
    logic [RW:0]            step_ext;
    logic [RW:0]            rem_step;
    logic [COORD_WIDTH-1:0] rem_c;
    logic [COORD_WIDTH-1:0] op_abs;

    assign trial    = {rem_reg, mag_reg[COORD_WIDTH-1]};
    assign step_ext = (RW + 1)'(step);
    assign rem_step = (trial >= step_ext) ? (trial - step_ext) : trial;
    assign op_abs   = operand[COORD_WIDTH-1] ? (~operand + 1'b1) : operand;
    assign rem_c    = rem_reg[COORD_WIDTH-1:0];

    assign result = orig_reg[COORD_WIDTH-1] ? (orig_reg + rem_c) : (orig_reg - rem_c);
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg  <= op_abs;
            rem_reg  <= '0;
            orig_reg <= operand;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[COORD_WIDTH-2:0], 1'b0};
            rem_reg <= rem_step[RW-1:0];
        end
    end

    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("snap unit busy and done together");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("snap unit restarted while busy");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && $past(busy_reg)) |-> (rem_reg < RW'(step)))
        else $error("partial remainder not below step");

endmodule

>>> design/polyline_grid_snap_dedup.sv
// ----------------------------------------------------------------------------
// polyline_grid_snap_dedup: grid snap and duplicate removal for vertex streams
// Snaps each vertex to the configured grid, drops repeats of the previous kept
// vertex (and in ring mode of any kept vertex), closes valid rings and ends
// each line with a status beat.
// Flow: a vertex is taken only when idle, so a new vertex waits until the
//   previous one is finished. Its handling is paced by the shared snap divider
//   (one bit per cycle, x then y), by the ring store search in ring mode and
//   by output back-pressure. A last vertex also brings the closing vertex of
//   a valid ring and the end beat.
// Reset: asynchronous, clears control state and line state; grid_step = 256,
//   ring_mode = 0. The ring store needs no clearing.
// ----------------------------------------------------------------------------
module polyline_grid_snap_dedup #(
    parameter int MAX_RING_POINTS = 256,
    parameter int COORD_WIDTH     = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pgsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pgsd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COORD_WIDTH-1:0]     x_coord,
    input  logic signed [COORD_WIDTH-1:0]     y_coord,
    input  logic                              last_vertex,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [COORD_WIDTH-1:0]     out_x,
    output logic signed [COORD_WIDTH-1:0]     out_y,
    output logic                              is_end_marker,
    output logic [1:0]                        status,
    output logic                              last_result
);
    import pgsd_pkg::*;

    localparam int AW = $clog2(MAX_RING_POINTS);
    localparam int KW = $clog2(MAX_RING_POINTS + 1);
    localparam logic [KW-1:0] KMAX = KW'(MAX_RING_POINTS);

    pgsd_state_t state_reg, state_next;

    logic [STEP_W-1:0]            grid_step_reg;
    logic                         ring_mode_reg;

    logic signed [COORD_WIDTH-1:0] y_hold_reg;
    logic                          last_reg;
    logic signed [COORD_WIDTH-1:0] sx_reg, sx_next;
    logic signed [COORD_WIDTH-1:0] sy_reg, sy_next;
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_x_next;
    logic signed [COORD_WIDTH-1:0] prev_y_reg, prev_y_next;
    logic                          prev_valid_reg, prev_valid_next;
    logic [KW-1:0]                 kept_count_reg, kept_count_next;
    logic                          overflowed_reg, overflowed_next;
    logic [AW-1:0]                 idx_reg, idx_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [COORD_WIDTH-1:0] out_x_reg, out_x_next;
    logic signed [COORD_WIDTH-1:0] out_y_reg, out_y_next;
    logic                          out_end_reg, out_end_next;
    logic [1:0]                    out_status_reg, out_status_next;

    logic signed [COORD_WIDTH-1:0] store_x [MAX_RING_POINTS];
    logic signed [COORD_WIDTH-1:0] store_y [MAX_RING_POINTS];
    logic signed [COORD_WIDTH-1:0] rd_x_reg, rd_y_reg;
    logic                          mem_we;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;

    logic                          snap_start;
    logic signed [COORD_WIDTH-1:0] snap_operand;
    logic [STEP_W-1:0]             eff_step;
    pgsd_snap_stat_t               snap_stat;
    logic signed [COORD_WIDTH-1:0] snap_result;

    logic         in_fire;
    logic         cfg_fire;
    logic         slot_free;
    logic         out_load;
    logic         dup_prev;
    logic         hit;
    logic         idx_last;
    logic         room;
    pgsd_status_t status_now;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    assign eff_step = (grid_step_reg == '0) ? STEP_W'(1) : grid_step_reg;
    assign dup_prev = prev_valid_reg && (sx_reg == prev_x_reg) && (sy_reg == prev_y_reg);
    assign hit      = (rd_x_reg == sx_reg) && (rd_y_reg == sy_reg);
    assign idx_last = ((KW'(idx_reg) + KW'(1)) == kept_count_reg);
    assign room     = (kept_count_reg < KMAX);

    always_comb
    begin
        if (overflowed_reg)
            status_now = STATUS_OVERFLOW;
        else if ((kept_count_reg < KW'(MIN_LINE_PTS)) ||
                 (ring_mode_reg && (kept_count_reg < KW'(MIN_RING_PTS))))
            status_now = STATUS_TOO_FEW;
        else
            status_now = STATUS_OK;
    end

    pgsd_snap_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_snap (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (snap_start),
        .operand (snap_operand),
        .step    (eff_step),
        .stat    (snap_stat),
        .result  (snap_result)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_fire) state_next = ST_DIV_X;
            ST_DIV_X:      if (snap_stat.done) state_next = ST_DIV_Y;
            ST_DIV_Y:      if (snap_stat.done) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (dup_prev)
                    state_next = ST_FINISH;
                else if (ring_mode_reg && (kept_count_reg != '0))
                    state_next = ST_SEARCH_RD;
                else
                    state_next = ST_COMMIT;
            end
            ST_SEARCH_RD:  state_next = ST_SEARCH_CMP;
            ST_SEARCH_CMP:
            begin
                if (hit)
                    state_next = ST_FINISH;
                else if (idx_last)
                    state_next = ST_COMMIT;
                else
                    state_next = ST_SEARCH_RD;
            end
            ST_COMMIT:
            begin
                if (room || !ring_mode_reg)
                    state_next = ST_EMIT_VTX;
                else
                    state_next = ST_FINISH;
            end
            ST_EMIT_VTX:   if (slot_free) state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (ring_mode_reg && (status_now == STATUS_OK))
                    state_next = ST_CLOSE_RD;
                else
                    state_next = ST_EMIT_END;
            end
            ST_CLOSE_RD:   state_next = ST_EMIT_CLOSE;
            ST_EMIT_CLOSE: if (slot_free) state_next = ST_EMIT_END;
            ST_EMIT_END:   if (slot_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        sx_next         = sx_reg;
        sy_next         = sy_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        prev_valid_next = prev_valid_reg;
        kept_count_next = kept_count_reg;
        overflowed_next = overflowed_reg;
        idx_next        = idx_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_end_next    = out_end_reg;
        out_status_next = out_status_reg;
        out_load        = 1'b0;
        snap_start      = 1'b0;
        snap_operand    = x_coord;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                snap_start = in_fire;
            end
            ST_DIV_X:
            begin
                snap_operand = y_hold_reg;
                if (snap_stat.done)
                begin
                    sx_next    = snap_result;
                    snap_start = 1'b1;
                end
            end
            ST_DIV_Y:
            begin
                if (snap_stat.done)
                    sy_next = snap_result;
                idx_next = '0;
            end
            ST_SEARCH_RD:
            begin
                rd_en = 1'b1;
            end
            ST_SEARCH_CMP:
            begin
                idx_next = idx_reg + 1'b1;
            end
            ST_COMMIT:
            begin
                if (room)
                begin
                    mem_we          = 1'b1;
                    kept_count_next = kept_count_reg + 1'b1;
                end
                if (room || !ring_mode_reg)
                begin
                    prev_x_next     = sx_reg;
                    prev_y_next     = sy_reg;
                    prev_valid_next = 1'b1;
                end
                else
                begin
                    overflowed_next = 1'b1;
                end
            end
            ST_EMIT_VTX:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_x_next      = sx_reg;
                    out_y_next      = sy_reg;
                    out_end_next    = 1'b0;
                    out_status_next = STATUS_OK;
                end
            end
            ST_CLOSE_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ST_EMIT_CLOSE:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_x_next      = rd_x_reg;
                    out_y_next      = rd_y_reg;
                    out_end_next    = 1'b0;
                    out_status_next = STATUS_OK;
                end
            end
            ST_EMIT_END:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_x_next      = '0;
                    out_y_next      = '0;
                    out_end_next    = 1'b1;
                    out_status_next = status_now;
                    prev_valid_next = 1'b0;
                    kept_count_next = '0;
                    overflowed_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_valid_reg <= 1'b0;
            kept_count_reg <= '0;
            overflowed_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            grid_step_reg  <= STEP_W'(GRID_STEP_RESET);
            ring_mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_valid_reg <= prev_valid_next;
            kept_count_reg <= kept_count_next;
            overflowed_reg <= overflowed_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    REG_GRID_STEP: grid_step_reg <= cfg_data[STEP_W-1:0];
                    REG_RING_MODE: ring_mode_reg <= cfg_data[0];
                    default:       ring_mode_reg <= ring_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            y_hold_reg <= y_coord;
            last_reg   <= last_vertex;
        end
        sx_reg         <= sx_next;
        sy_reg         <= sy_next;
        prev_x_reg     <= prev_x_next;
        prev_y_reg     <= prev_y_next;
        idx_reg        <= idx_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_end_reg    <= out_end_next;
        out_status_reg <= out_status_next;
    end

    // ring store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_x[kept_count_reg[AW-1:0]] <= sx_reg;
            store_y[kept_count_reg[AW-1:0]] <= sy_reg;
        end
        if (rd_en)
        begin
            rd_x_reg <= store_x[rd_addr];
            rd_y_reg <= store_y[rd_addr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign is_end_marker = out_end_reg;
    assign status        = out_status_reg;
    assign last_result   = out_end_reg;

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= KMAX)
        else $error("kept count beyond store depth");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> (kept_count_reg == KMAX))
        else $error("overflow flagged with room in store");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("output beat overwritten");

    a_line_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT_END && slot_free) |=>
        (kept_count_reg == '0 && !prev_valid_reg && !overflowed_reg))
        else $error("line state not cleared after end beat");

endmodule
